// ----- hdl/spectrum_column_peak_hold_render_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum column renderer
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_COLUMN_PEAK_HOLD_RENDER_CORE_MACROS_SVH
`define SPECTRUM_COLUMN_PEAK_HOLD_RENDER_CORE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define SCPHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCPHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/scphr_pkg.sv -----
// ----------------------------------------------------------------------------
// scphr_pkg
// Shared constants and types of the spectrum column peak-hold renderer.
// ----------------------------------------------------------------------------
package scphr_pkg;

    localparam int COLUMNS_DEF    = 320;
    localparam int BAR_HEIGHT_DEF = 48;

    localparam logic signed [8:0] HOLD_FLOOR = -9'sd240;
    localparam int SPAN_HALF_DB = 200;
    localparam int SEG_LEN      = 50;
    localparam int DECAY_STEP   = 4;
    localparam int CHAN_MAX     = 255;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_DECAY  = 1'b1
    } kind_t;

endpackage

// ----- hdl/scphr_hold_mem.sv -----
// ----------------------------------------------------------------------------
// scphr_hold_mem
// Per-column peak-hold memory, one read and one write port, registered read,
// with a clearing pass after reset.
// ----------------------------------------------------------------------------
module scphr_hold_mem
    import scphr_pkg::*;
#(
    parameter int Columns = COLUMNS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(Columns)-1:0] rd_addr,
    output logic signed [8:0]          rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(Columns)-1:0] wr_addr,
    input  logic signed [8:0]          wr_data,
    output logic                       clearing
);

    localparam int AddrW = $clog2(Columns);

    logic signed [8:0] mem [0:Columns-1];
    logic signed [8:0] rd_data_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [AddrW-1:0]  clr_addr_reg;
    logic [AddrW-1:0]  clr_addr_next;
    logic              mem_we;
    logic [AddrW-1:0]  mem_waddr;
    logic signed [8:0] mem_wdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AddrW'(Columns - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
        mem_we    = clr_busy_reg ? 1'b1 : wr_en;
        mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? HOLD_FLOOR : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

// ----- hdl/scphr_render.sv -----
// ----------------------------------------------------------------------------
// scphr_render
// Hold update and rendering of one item: heat-map color, bar height and
// peak-dot row.
// ----------------------------------------------------------------------------
module scphr_render
    import scphr_pkg::*;
#(
    parameter int BarHeight = BAR_HEIGHT_DEF
)
(
    input  logic              kind,
    input  logic signed [8:0] rssi_half_db,
    input  logic signed [8:0] old_hold,
    output logic signed [8:0] new_hold,
    output logic [15:0]       pixel_color,
    output logic [5:0]        bar_height,
    output logic [5:0]        peak_row,
    output logic              peak_visible
);

    logic [7:0] scale_lut [0:SPAN_HALF_DB];
    logic [7:0] ramp_lut  [0:SEG_LEN];

    for (genvar i = 0; i <= SPAN_HALF_DB; i++)
    begin : g_scale
        assign scale_lut[i] = 8'((i * BarHeight) / SPAN_HALF_DB);
    end

    for (genvar i = 0; i <= SEG_LEN; i++)
    begin : g_ramp
        assign ramp_lut[i] = 8'((CHAN_MAX * i) / SEG_LEN);
    end

    logic signed [10:0] decayed;
    logic signed [10:0] dv;
    logic signed [10:0] pv;
    logic [7:0]         d;
    logic [7:0]         p;
    logic [7:0]         bar;
    logic [7:0]         pk;
    logic [7:0]         row;
    logic [1:0]         seg;
    logic [5:0]         x;
    logic [7:0]         up_val;
    logic [7:0]         dn_val;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;

    always_comb
    begin
        decayed = 11'(old_hold) - 11'(DECAY_STEP);
        if (kind == KIND_DECAY)
        begin
            new_hold = (decayed < 11'(HOLD_FLOOR)) ? HOLD_FLOOR : 9'(decayed);
        end
        else
        begin
            new_hold = (rssi_half_db > old_hold) ? rssi_half_db : old_hold;
        end

        dv = 11'(rssi_half_db) - 11'(HOLD_FLOOR);
        if (dv < 11'sd0)
        begin
            d = 8'd0;
        end
        else if (dv > 11'(SPAN_HALF_DB))
        begin
            d = 8'(SPAN_HALF_DB);
        end
        else
        begin
            d = 8'(dv);
        end

        pv = 11'(new_hold) - 11'(HOLD_FLOOR);
        p  = (pv > 11'(SPAN_HALF_DB)) ? 8'(SPAN_HALF_DB) : 8'(pv);

        bar = scale_lut[d];
        if (bar == 8'd0)
        begin
            bar = 8'd1;
        end
        pk  = scale_lut[p];
        row = 8'(BarHeight) - pk;

        if (d < 8'(SEG_LEN))
        begin
            seg = 2'd0;
            x   = 6'(d);
        end
        else if (d < 8'(2 * SEG_LEN))
        begin
            seg = 2'd1;
            x   = 6'(d - 8'(SEG_LEN));
        end
        else if (d < 8'(3 * SEG_LEN))
        begin
            seg = 2'd2;
            x   = 6'(d - 8'(2 * SEG_LEN));
        end
        else
        begin
            seg = 2'd3;
            x   = 6'(d - 8'(3 * SEG_LEN));
        end

        up_val = ramp_lut[x];
        dn_val = ramp_lut[6'(SEG_LEN) - x];

        case (seg)
            2'd0:
            begin
                r = 8'd0;
                g = up_val;
                b = 8'(CHAN_MAX);
            end
            2'd1:
            begin
                r = 8'd0;
                g = 8'(CHAN_MAX);
                b = dn_val;
            end
            2'd2:
            begin
                r = up_val;
                g = 8'(CHAN_MAX);
                b = 8'd0;
            end
            default:
            begin
                r = 8'(CHAN_MAX);
                g = dn_val;
                b = 8'd0;
            end
        endcase

        pixel_color  = {r[7:3], g[7:2], b[7:3]};
        bar_height   = bar[5:0];
        peak_row     = row[5:0];
        peak_visible = (pk != 8'd0);
    end

endmodule

// ----- hdl/spectrum_column_peak_hold_render_core.sv -----
// ----------------------------------------------------------------------------
// spectrum_column_peak_hold_render_core
// Renders one spectrum column per sample item with a per-column peak hold.
// ----------------------------------------------------------------------------
// Result path: an accepted item is loaded into the s1 registers with its hold
//   read; a sample item's result is then registered at the output once free.
// Throughput: one item per cycle while in_stall is low; each item is a hold
//   memory read-modify-write, forwarded between consecutive same-column items.
// Reset: control clears at once, then a clearing pass writes -240 to all
//   Columns entries, one per cycle; in_stall is high throughout the pass.
module spectrum_column_peak_hold_render_core
    import scphr_pkg::*;
#(
    parameter int Columns   = COLUMNS_DEF,
    parameter int BarHeight = BAR_HEIGHT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [8:0]        column,
    input  logic signed [8:0] rssi_half_db,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [8:0]        out_column,
    output logic [15:0]       pixel_color,
    output logic [5:0]        bar_height,
    output logic [5:0]        peak_row,
    output logic              peak_visible
);

    localparam int AddrW = $clog2(Columns);

    logic              clearing;
    logic              accept;
    logic              in_range;
    logic              s1_load;
    logic              s1_go;
    logic              out_free;
    logic signed [8:0] rd_data;
    logic signed [8:0] old_hold;
    logic signed [8:0] new_hold;
    logic [15:0]       r_color;
    logic [5:0]        r_bar;
    logic [5:0]        r_row;
    logic              r_visible;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_kind_reg;
    logic [8:0]        s1_col_reg;
    logic signed [8:0] s1_rssi_reg;
    logic              byp_hit_reg;
    logic signed [8:0] byp_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [8:0]        out_column_reg;
    logic [15:0]       pixel_color_reg;
    logic [5:0]        bar_height_reg;
    logic [5:0]        peak_row_reg;
    logic              peak_visible_reg;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        s1_go    = s1_valid_reg && ((s1_kind_reg == KIND_DECAY) || out_free);
        in_stall = clearing || (s1_valid_reg && !s1_go);
        accept   = in_valid && !in_stall;
        in_range = ({2'b00, column} < 11'(Columns));
        s1_load  = accept && in_range;

        s1_valid_next = s1_load ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

        out_valid_next = out_valid_reg;
        if (s1_go && (s1_kind_reg == KIND_SAMPLE))
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        old_hold = byp_hit_reg ? byp_data_reg : rd_data;
    end

    scphr_hold_mem #(
        .Columns (Columns)
    ) u_hold_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (s1_load),
        .rd_addr  (AddrW'(column)),
        .rd_data  (rd_data),
        .wr_en    (s1_go),
        .wr_addr  (AddrW'(s1_col_reg)),
        .wr_data  (new_hold),
        .clearing (clearing)
    );

    scphr_render #(
        .BarHeight (BarHeight)
    ) u_render (
        .kind         (s1_kind_reg),
        .rssi_half_db (s1_rssi_reg),
        .old_hold     (old_hold),
        .new_hold     (new_hold),
        .pixel_color  (r_color),
        .bar_height   (r_bar),
        .peak_row     (r_row),
        .peak_visible (r_visible)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg  <= kind;
            s1_col_reg   <= column;
            s1_rssi_reg  <= rssi_half_db;
            // previous item writes this column at the same edge as our read
            byp_hit_reg  <= s1_go && (s1_col_reg == column);
            byp_data_reg <= new_hold;
        end
        if (s1_go && (s1_kind_reg == KIND_SAMPLE))
        begin
            out_column_reg   <= s1_col_reg;
            pixel_color_reg  <= r_color;
            bar_height_reg   <= r_bar;
            peak_row_reg     <= r_row;
            peak_visible_reg <= r_visible;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_column   = out_column_reg;
    assign pixel_color  = pixel_color_reg;
    assign bar_height   = bar_height_reg;
    assign peak_row     = peak_row_reg;
    assign peak_visible = peak_visible_reg;

endmodule

// ----- hdl/scphr_checker.sv -----
// ----------------------------------------------------------------------------
// scphr_checker
// Port-level checks of the spectrum column renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "spectrum_column_peak_hold_render_core_macros.svh"

module scphr_checker
    import scphr_pkg::*;
#(
    parameter int Columns   = COLUMNS_DEF,
    parameter int BarHeight = BAR_HEIGHT_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              kind,
    input logic [8:0]        column,
    input logic signed [8:0] rssi_half_db,
    input logic              out_valid,
    input logic              out_stall,
    input logic [8:0]        out_column,
    input logic [15:0]       pixel_color,
    input logic [5:0]        bar_height,
    input logic [5:0]        peak_row,
    input logic              peak_visible
);

    `SCPHR_ASSERT_NOW(a_col_in_range, out_valid, ({2'b00, out_column} < 11'(Columns)), "result column out of range")
    `SCPHR_ASSERT_NOW(a_bar_nonzero, out_valid && (BarHeight < 64), (bar_height != 6'd0), "zero bar height")
    `SCPHR_ASSERT_NOW(a_hidden_row, out_valid && !peak_visible, (peak_row == 6'(BarHeight)), "hidden peak not at strip bottom")
    `SCPHR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_column) && $stable(pixel_color) && $stable(bar_height) && $stable(peak_row) && $stable(peak_visible), "stalled item changed")

endmodule

bind spectrum_column_peak_hold_render_core scphr_checker #(
    .Columns   (Columns),
    .BarHeight (BarHeight)
) u_scphr_checker (.*);
